@@ src/md5_pkg.sv @@
package md5_pkg;

    // Width of the message byte count; the bit length is this count times eight.
    localparam int COUNT_W = 61;

    // Chaining word values at the start of every message.
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // Padding marker byte.
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       write_byte;  // store the input byte and bump the count
        logic       start;       // copy chaining words into the working words
        logic       round;       // run one compression round
        logic [5:0] ridx;        // round number, 0 to 63
        logic       fold;        // add working words into the chaining words
        logic       pad;         // write 0x80, zero the tail, maybe the length
        logic       pad_len;     // zero the whole block and write the length
        logic       emit;        // load the digest register and restart
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic blk_full;  // the next byte completes the block
        logic pad_wrap;  // at most 8 free bytes, length needs an extra block
    } t_status;

    // Additive constant of each round.
    function automatic logic [31:0] sine_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
                6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
                6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
                6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
                6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
                6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
                6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
                6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
                6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
                6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
                6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
                6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
                6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
                6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
                6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
                6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
                6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
                6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
                6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
                6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
                6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
                6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
                6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
                6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
                6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
                6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
                6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
                6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
                6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
                6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
                6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
                6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    // Rotate amount, chosen by the stage and the low two bits of the round.
    function automatic logic [4:0] shift_amt(input logic [3:0] sel);
        logic [4:0] s;
        begin
            unique case (sel)
                4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
                4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
                4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
                4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
                4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
                4'd10: s = 5'd16;  4'd11: s = 5'd23;
                4'd12: s = 5'd6;   4'd13: s = 5'd10;
                4'd14: s = 5'd15;  4'd15: s = 5'd21;
                default: s = 5'd0;
            endcase
            return s;
        end
    endfunction

    // Block word used by a round.
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] g;
        begin
            rl = r[3:0];
            unique case (r[5:4])
                2'd0:    g = rl;
                2'd1:    g = (rl << 2) + rl + 4'd1;
                2'd2:    g = (rl << 1) + rl + 4'd5;
                default: g = (rl << 3) - rl;
            endcase
            return g;
        end
    endfunction

endpackage

@@ src/md5_message_digest.sv @@
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_data_byte, i_has_byte, i_last
// digest    out        o_valid / i_stall   o_digest_a, o_digest_b, o_digest_c, o_digest_d
//
// A byte that does not complete a 64-byte block is stored without compression. The byte
// that completes a block starts a compression: one round per cycle on the single round
// unit, then a fold into the chaining words. A last request adds a padding step and a
// compression, a second padding step and compression when the length needs an extra
// block, and a step that loads the digest register. Reset is synchronous and active low.
// A waiting digest holds in its register; the next message may start meanwhile.
module md5_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_a,
    output logic [31:0] o_digest_b,
    output logic [31:0] o_digest_c,
    output logic [31:0] o_digest_d
);
    import md5_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer for byte loading, rounds, padding and digest output.
    md5_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_has_byte (i_has_byte),
        .i_last     (i_last),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Block buffer, round unit and chaining words.
    md5_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_data_byte),
        .o_status    (status),
        .o_digest_a  (o_digest_a),
        .o_digest_b  (o_digest_b),
        .o_digest_c  (o_digest_c),
        .o_digest_d  (o_digest_d)
    );

endmodule

@@ src/md5_datapath.sv @@
module md5_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  md5_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_data_byte,
    output md5_pkg::t_status o_status,
    output logic [31:0]      o_digest_a,
    output logic [31:0]      o_digest_b,
    output logic [31:0]      o_digest_c,
    output logic [31:0]      o_digest_d
);
    import md5_pkg::*;

    logic [31:0]        r_chain [4];
    logic [31:0]        n_chain [4];
    logic [31:0]        r_work  [4];
    logic [31:0]        n_work  [4];
    logic [31:0]        r_block [16];
    logic [31:0]        n_block [16];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [31:0]        r_dig   [4];

    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [1:0]  stage;
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;

    assign pos     = r_count[5:0];
    assign bit_len = {r_count, 3'b000};

    assign o_status.blk_full = &pos;
    assign o_status.pad_wrap = &pos[5:3];

    // One compression round: mixing function, four-way add, rotate, add.
    assign stage = i_cmd.ridx[5:4];
    always_comb begin
        unique case (stage)
            2'd0:    f = (r_work[1] & r_work[2]) | (~r_work[1] & r_work[3]);
            2'd1:    f = (r_work[1] & r_work[3]) | (r_work[2] & ~r_work[3]);
            2'd2:    f = r_work[1] ^ r_work[2] ^ r_work[3];
            default: f = r_work[2] ^ (r_work[1] | ~r_work[3]);
        endcase
    end

    assign sum      = f + r_work[0] + sine_k(i_cmd.ridx) + r_block[msg_index(i_cmd.ridx)];
    assign rot_wide = {sum, sum} << shift_amt({stage, i_cmd.ridx[1:0]});
    assign new_b    = r_work[1] + rot_wide[63:32];

    // Working words: loaded from the chaining words, then shifted each round.
    always_comb begin
        n_work = r_work;
        if (i_cmd.start) begin
            n_work = r_chain;
        end else if (i_cmd.round) begin
            n_work[0] = r_work[3];
            n_work[1] = new_b;
            n_work[2] = r_work[1];
            n_work[3] = r_work[2];
        end
    end

    // Block buffer: byte writes and the two padding forms.
    always_comb begin
        logic [5:0] p;
        n_block = r_block;
        p       = 6'd0;
        for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
                p = {4'(w), 2'(b)};
                if (i_cmd.write_byte && p == pos) begin
                    n_block[w][b*8 +: 8] = i_data_byte;
                end
                if (i_cmd.pad) begin
                    if (p == pos) begin
                        n_block[w][b*8 +: 8] = PAD_BYTE;
                    end else if (p > pos) begin
                        n_block[w][b*8 +: 8] = 8'h00;
                    end
                end
                if (i_cmd.pad_len) begin
                    n_block[w][b*8 +: 8] = 8'h00;
                end
            end
        end
        if ((i_cmd.pad && !o_status.pad_wrap) || i_cmd.pad_len) begin
            n_block[14] = bit_len[31:0];
            n_block[15] = bit_len[63:32];
        end
    end

    // Chaining words and byte count.
    always_comb begin
        n_chain = r_chain;
        n_count = r_count;
        if (i_cmd.write_byte) begin
            n_count = r_count + COUNT_W'(1);
        end
        if (i_cmd.fold) begin
            for (int i = 0; i < 4; i++) begin
                n_chain[i] = r_chain[i] + r_work[i];
            end
        end
        if (i_cmd.emit) begin
            n_chain[0] = INIT_A;
            n_chain[1] = INIT_B;
            n_chain[2] = INIT_C;
            n_chain[3] = INIT_D;
            n_count    = '0;
        end
    end

    // Message state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain[0] <= INIT_A;
            r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C;
            r_chain[3] <= INIT_D;
            r_count    <= '0;
        end else begin
            r_chain <= n_chain;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_block <= n_block;
        if (i_cmd.emit) begin
            r_dig <= r_chain;
        end
    end

    assign o_digest_a = r_dig[0];
    assign o_digest_b = r_dig[1];
    assign o_digest_c = r_dig[2];
    assign o_digest_d = r_dig[3];

endmodule

@@ src/md5_ctrl.sv @@
module md5_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_has_byte,
    input  logic             i_last,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  md5_pkg::t_status i_status,
    output md5_pkg::t_cmd    o_cmd
);
    import md5_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROUND  = 3'd1;
    localparam logic [2:0] ST_FOLD   = 3'd2;
    localparam logic [2:0] ST_PAD    = 3'd3;
    localparam logic [2:0] ST_PADLEN = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    // Where to go once a compression has been folded in.
    localparam logic [1:0] AFT_IDLE   = 2'd0;
    localparam logic [1:0] AFT_PAD    = 2'd1;
    localparam logic [1:0] AFT_PADLEN = 2'd2;
    localparam logic [1:0] AFT_EMIT   = 2'd3;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_after;
    logic [1:0] n_after;
    logic [5:0] r_ridx;
    logic [5:0] n_ridx;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_out_valid;

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_ridx      = r_ridx;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        o_cmd.ridx  = r_ridx;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.write_byte = i_has_byte;
                    if (i_has_byte && i_status.blk_full) begin
                        o_cmd.start = 1'b1;
                        n_ridx      = 6'd0;
                        n_after     = i_last ? AFT_PAD : AFT_IDLE;
                        n_state     = ST_ROUND;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                n_ridx      = r_ridx + 6'd1;
                if (&r_ridx) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                unique case (r_after)
                    AFT_IDLE:   n_state = ST_IDLE;
                    AFT_PAD:    n_state = ST_PAD;
                    AFT_PADLEN: n_state = ST_PADLEN;
                    default:    n_state = ST_EMIT;
                endcase
            end
            ST_PAD: begin
                o_cmd.pad   = 1'b1;
                o_cmd.start = 1'b1;
                n_ridx      = 6'd0;
                n_after     = i_status.pad_wrap ? AFT_PADLEN : AFT_EMIT;
                n_state     = ST_ROUND;
            end
            ST_PADLEN: begin
                o_cmd.pad_len = 1'b1;
                o_cmd.start   = 1'b1;
                n_ridx        = 6'd0;
                n_after       = AFT_EMIT;
                n_state       = ST_ROUND;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= AFT_IDLE;
            r_ridx      <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_ridx      <= n_ridx;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
